/* design/msbc_pkg.sv */
package msbc_pkg;

  localparam int BufBytes   = 120;
  localparam int PtrW       = 7;
  localparam int Window     = 60;
  localparam int PayloadLen = 57;

  localparam logic [7:0] Hdr0 = 8'h01;
  localparam logic [7:0] Sync = 8'hAD;
  localparam logic [7:0] Seq0 = 8'h08;
  localparam logic [7:0] Seq1 = 8'h38;
  localparam logic [7:0] Seq2 = 8'hC8;
  localparam logic [7:0] Seq3 = 8'hF8;

  localparam logic [5:0] PktShort = 6'd24;
  localparam logic [5:0] PktLong  = 6'd60;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_LOST    = 2'd1;
  localparam logic [1:0] KIND_LEN_ERR = 2'd2;

  typedef struct packed {
    logic       hit;
    logic [1:0] seq;
  } scan_t;

  function automatic scan_t seq_decode(input logic [7:0] v);
    scan_t r;
    r.hit = 1'b1;
    r.seq = 2'd0;
    unique case (v)
      Seq0: r.seq = 2'd0;
      Seq1: r.seq = 2'd1;
      Seq2: r.seq = 2'd2;
      Seq3: r.seq = 2'd3;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* design/msbc_scan.sv */
module msbc_scan (
  input  logic             clk,
  input  logic             data_valid,
  input  logic [7:0]       data,
  input  logic             check,
  output msbc_pkg::scan_t  match
);
  import msbc_pkg::*;

  logic [7:0] sh0;
  logic [7:0] sh1;
  scan_t      dec;

  // last two bytes read from the store
  always_ff @(posedge clk) begin
    if (data_valid) begin
      sh1 <= sh0;
      sh0 <= data;
    end
  end

  always_comb begin
    dec       = seq_decode(sh0);
    match.seq = dec.seq;
    match.hit = data_valid && check && dec.hit && (sh1 == Hdr0) && (data == Sync);
  end

endmodule

/* design/msbc_h2_sco_deframer.sv */
// channel  | dir | signals                                            | request
// ---------+-----+----------------------------------------------------+-----------------
// cfg      | in  | cfg_valid, cfg_ready, packet_bytes                 | valid & ready
// in       | in  | in_valid, in_stall, sco_byte, packet_status,       | valid & !stall
//          |     | packet_end                                         |
// out      | out | out_valid, out_stall, kind, payload_byte,          | valid & !stall
//          |     | frame_seq, frames_total, lost_total, run_last      |
//
// a byte that does not end a packet is stored and counted; a packet end that completes
// the 60-byte window scans the byte store one address per cycle unless corrupt, emits
// up to three lost markers, then if a frame was found streams 57 payload bytes off the
// single store read port, markers and bytes at one per cycle unless the output stalls.
// reset is synchronous and clears control state only; the byte store is not cleared.
// a stalled output holds its request; a new input request waits until results are out.
module msbc_h2_sco_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  packet_bytes,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  sco_byte,
  input  logic [7:0]  packet_status,
  input  logic        packet_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [1:0]  frame_seq,
  output logic [31:0] frames_total,
  output logic [31:0] lost_total,
  output logic        run_last
);
  import msbc_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_LOSS   = 2'd2;
  localparam logic [1:0] ST_PAY    = 2'd3;

  logic [7:0] store [BufBytes];

  logic [1:0]      state;
  logic [5:0]      size_reg;
  logic            aligned;
  logic            corrupt;
  logic [PtrW-1:0] rp;
  logic [PtrW-1:0] wp;
  logic [5:0]      pcount;
  logic [7:0]      hdr0;
  logic [7:0]      hdr2;
  logic [31:0]     fc;
  logic [31:0]     lc;
  logic [PtrW-1:0] sbase;
  logic [PtrW-1:0] slast;
  logic [PtrW-1:0] ri;
  logic            rv;
  logic [PtrW-1:0] rj;
  logic            fnd;
  logic [1:0]      fseq;
  logic [PtrW-1:0] fpos;
  logic [5:0]      k;
  logic [5:0]      ocnt;
  logic            rd_pend;
  logic [7:0]      rdata;

  logic            cfg_acc;
  logic            in_acc;
  logic            out_free;
  logic [PtrW-1:0] size7;
  logic            len_ok;
  logic            hdr_ok;
  logic [7:0]      widx;
  logic            we;
  logic [PtrW-1:0] wp_new;
  logic [7:0]      rp_win;
  logic            set_corrupt;
  logic            wait_more;
  logic [PtrW-1:0] span;
  logic            srch_issue;
  logic            pay_issue;
  logic            re;
  logic [PtrW-1:0] raddr;
  logic            loss_emit;
  logic            pay_load;
  logic            len_err;
  logic            out_load;
  logic [1:0]      kind_d;
  logic [7:0]      byte_d;
  logic [1:0]      seq_d;
  logic [31:0]     ft_d;
  logic [31:0]     lt_d;
  logic            last_d;
  scan_t           match;

  assign cfg_ready = (state == ST_IDLE);
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE) || (out_valid && out_stall);
  assign in_acc    = in_valid && !in_stall;

  assign size7  = (size_reg == PktShort) ? PtrW'(PktShort) : PtrW'(PktLong);
  assign len_ok = ({1'b0, pcount} + 7'd1) == size7;
  assign hdr_ok = (hdr0 == Hdr0) && (hdr2 == Sync);

  assign widx = {1'b0, wp} + {2'b00, pcount};
  assign we   = in_acc && ({1'b0, pcount} < size7) && (widx < 8'(BufBytes));

  assign wp_new      = wp + size7;
  assign rp_win      = {1'b0, rp} + 8'(Window);
  assign set_corrupt = (rp_win >= {1'b0, wp_new}) && (packet_status != 8'd0);
  assign wait_more   = rp_win > {1'b0, wp_new};
  assign span        = wp_new - rp;

  assign len_err = in_acc && packet_end && !len_ok;

  assign srch_issue = (state == ST_SEARCH) && (ri <= slast);
  assign pay_issue  = (state == ST_PAY) && (k < 6'(PayloadLen)) && (!rd_pend || out_free);
  assign re         = srch_issue || pay_issue;
  assign raddr      = (state == ST_SEARCH) ? (sbase + ri) : (fpos + 7'd2 + {1'b0, k});

  assign loss_emit = (state == ST_LOSS) && out_free && (!fnd || (fseq != fc[1:0]));
  assign pay_load  = (state == ST_PAY) && rd_pend && out_free;
  assign out_load  = len_err || loss_emit || pay_load;

  msbc_scan u_scan (
    .clk        (clk),
    .data_valid (rv),
    .data       (rdata),
    .check      (rj >= 7'd2),
    .match      (match)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      store[widx[PtrW-1:0]] <= sco_byte;
    end
    if (re) begin
      rdata <= store[raddr];
    end
  end

  always_comb begin
    kind_d = KIND_PAYLOAD;
    byte_d = 8'd0;
    seq_d  = 2'd0;
    ft_d   = fc;
    lt_d   = lc;
    last_d = 1'b1;
    priority if (len_err) begin
      kind_d = KIND_LEN_ERR;
    end else if (loss_emit) begin
      kind_d = KIND_LOST;
      seq_d  = fc[1:0];
      ft_d   = fc + 32'd1;
      lt_d   = lc + 32'd1;
      last_d = !fnd;
    end else begin
      byte_d = rdata;
      seq_d  = fseq;
      last_d = (ocnt == 6'(PayloadLen - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind         <= kind_d;
      payload_byte <= byte_d;
      frame_seq    <= seq_d;
      frames_total <= ft_d;
      lost_total   <= lt_d;
      run_last     <= last_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      size_reg  <= PktLong;
      aligned   <= 1'b1;
      corrupt   <= 1'b0;
      rp        <= '0;
      wp        <= '0;
      pcount    <= '0;
      fc        <= '0;
      lc        <= '0;
      ri        <= '0;
      rv        <= 1'b0;
      rj        <= '0;
      fnd       <= 1'b0;
      k         <= '0;
      ocnt      <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (pcount == 6'd0) begin
              hdr0 <= sco_byte;
            end
            if (pcount == 6'd2) begin
              hdr2 <= sco_byte;
            end
            if (!packet_end) begin
              pcount <= (pcount < 6'd63) ? pcount + 6'd1 : 6'd63;
            end else begin
              pcount <= '0;
              if (len_ok && (aligned || hdr_ok)) begin
                aligned <= 1'b1;
                wp      <= wp_new;
                if (set_corrupt) begin
                  corrupt <= 1'b1;
                end
                if (!wait_more) begin
                  sbase <= rp;
                  slast <= span - 7'(PayloadLen);
                  if (rp_win[PtrW-1:0] == wp_new) begin
                    rp <= '0;
                    wp <= '0;
                  end else begin
                    rp <= rp_win[PtrW-1:0];
                  end
                  if (corrupt || set_corrupt) begin
                    corrupt <= 1'b0;
                    fnd     <= 1'b0;
                    state   <= ST_LOSS;
                  end else begin
                    ri    <= '0;
                    rv    <= 1'b0;
                    state <= ST_SEARCH;
                  end
                end
              end
            end
          end
          if (cfg_acc) begin
            size_reg <= packet_bytes;
            aligned  <= (packet_bytes != PktShort);
            corrupt  <= 1'b0;
            rp       <= '0;
            wp       <= '0;
            pcount   <= '0;
            fc       <= '0;
            lc       <= '0;
          end
        end
        ST_SEARCH: begin
          rv <= srch_issue;
          rj <= ri;
          if (srch_issue) begin
            ri <= ri + 7'd1;
          end
          if (match.hit) begin
            fnd   <= 1'b1;
            fpos  <= sbase + rj - 7'd2;
            fseq  <= match.seq;
            rv    <= 1'b0;
            state <= ST_LOSS;
          end else if (rv && (rj == slast)) begin
            fnd   <= 1'b0;
            rv    <= 1'b0;
            state <= ST_LOSS;
          end
        end
        ST_LOSS: begin
          if (loss_emit) begin
            fc <= fc + 32'd1;
            lc <= lc + 32'd1;
            if (!fnd) begin
              state <= ST_IDLE;
            end
          end else if (fnd && (fseq == fc[1:0])) begin
            fc      <= fc + 32'd1;
            k       <= '0;
            ocnt    <= '0;
            rd_pend <= 1'b0;
            state   <= ST_PAY;
          end
        end
        ST_PAY: begin
          rd_pend <= pay_issue || (rd_pend && !out_free);
          if (pay_issue) begin
            k <= k + 6'd1;
          end
          if (pay_load) begin
            ocnt <= ocnt + 6'd1;
            if (ocnt == 6'(PayloadLen - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* sim/msbc_h2_sco_deframer_test.sv */
module msbc_h2_sco_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import msbc_pkg::*;

  localparam int FrameSpan = PayloadLen + 2;
  localparam int SettleCycles = 64;
  localparam int HoldCycles = 400;
  localparam int PhaseBytes = 120;
  localparam logic [7:0] SeqOctet [4] = '{Seq0, Seq1, Seq2, Seq3};

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [1:0]  seq;
    logic [31:0] frames;
    logic [31:0] lost;
    logic        last;
  } deframe_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  packet_bytes = PktLong;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  sco_byte = 8'h00;
  logic [7:0]  packet_status = 8'h00;
  logic        packet_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [1:0]  frame_seq;
  logic [31:0] frames_total;
  logic [31:0] lost_total;
  logic        run_last;

  msbc_h2_sco_deframer dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .packet_bytes(packet_bytes),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sco_byte(sco_byte),
    .packet_status(packet_status),
    .packet_end(packet_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .payload_byte(payload_byte),
    .frame_seq(frame_seq),
    .frames_total(frames_total),
    .lost_total(lost_total),
    .run_last(run_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // deframer mirror
  logic [7:0]   store_mem [BufBytes];
  int unsigned  rd_ptr;
  int unsigned  wr_ptr;
  int unsigned  pkt_len;
  bit           is_aligned;
  bit           bad_frame;
  logic [31:0]  frame_cnt;
  logic [31:0]  lost_cnt;
  logic [5:0]   size_reg;
  deframe_out_t frames_due[$];
  int           mismatches = 0;

  // stimulus side
  logic [7:0] tx_bytes[$];
  int         tx_seq = 0;
  int         pkt_size = 60;
  bit         quiet = 1'b0;
  int         hold_reqs = 0;
  int         hold_taken = 0;
  int         hold_left = 0;

  function automatic void restart_model();
    rd_ptr = 0;
    wr_ptr = 0;
    pkt_len = 0;
    is_aligned = (size_reg != PktShort);
    bad_frame = 1'b0;
    frame_cnt = '0;
    lost_cnt = '0;
  endfunction

  function automatic void apply_packet_size(logic [5:0] v);
    size_reg = v;
    restart_model();
  endfunction

  function automatic logic [7:0] store_at(int unsigned idx);
    return (idx < BufBytes) ? store_mem[idx] : 8'h00;
  endfunction

  function automatic int seq_index(logic [7:0] v);
    for (int i = 0; i < 4; i++)
      if (v == SeqOctet[i]) return i;
    return -1;
  endfunction

  function automatic void push_due(logic [1:0] k, logic [7:0] d, logic [1:0] s);
    deframe_out_t r;
    r.kind = k;
    r.data = d;
    r.seq = s;
    r.frames = frame_cnt;
    r.lost = lost_cnt;
    r.last = 1'b0;
    frames_due.push_back(r);
  endfunction

  function automatic void close_run();
    deframe_out_t r;
    r = frames_due.pop_back();
    r.last = 1'b1;
    frames_due.push_back(r);
  endfunction

  function automatic void mark_lost();
    logic [1:0] s;
    s = frame_cnt[1:0];
    frame_cnt = frame_cnt + 1;
    lost_cnt = lost_cnt + 1;
    push_due(KIND_LOST, 8'h00, s);
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic [7:0] st, logic last);
    int unsigned span;
    int unsigned n;
    int unsigned pos;
    int unsigned hit_at;
    int          s;
    bit          found;
    span = (size_reg == PktShort) ? 24 : 60;
    n = pkt_len;
    s = -1;
    found = 1'b0;
    hit_at = 0;
    if (n < span && wr_ptr + n < BufBytes) store_mem[wr_ptr + n] = b;
    if (!last) begin
      pkt_len = (n < 63) ? n + 1 : 63;
      return;
    end
    pkt_len = 0;
    if (n + 1 != span) begin
      push_due(KIND_LEN_ERR, 8'h00, 2'd0);
      close_run();
      return;
    end
    if (!is_aligned) begin
      if (store_at(wr_ptr) != Hdr0 || store_at(wr_ptr + 2) != Sync) return;
      is_aligned = 1'b1;
    end
    wr_ptr = (wr_ptr + span) % 128;
    if (rd_ptr + Window >= wr_ptr && st != 8'h00) bad_frame = 1'b1;
    if (rd_ptr + Window > wr_ptr) return;
    if (bad_frame) begin
      bad_frame = 1'b0;
    end else begin
      for (pos = 0; !found && pos + FrameSpan <= wr_ptr - rd_ptr; pos++) begin
        if (store_at(rd_ptr + pos) == Hdr0 && store_at(rd_ptr + pos + 2) == Sync) begin
          s = seq_index(store_at(rd_ptr + pos + 1));
          if (s >= 0) begin
            found = 1'b1;
            hit_at = rd_ptr + pos;
          end
        end
      end
    end
    rd_ptr = (rd_ptr + Window) % 128;
    if (rd_ptr == wr_ptr) begin
      rd_ptr = 0;
      wr_ptr = 0;
    end
    if (!found) begin
      mark_lost();
    end else begin
      while (s != int'(frame_cnt[1:0])) mark_lost();
      frame_cnt = frame_cnt + 1;
      for (int k = 0; k < PayloadLen; k++)
        push_due(KIND_PAYLOAD, store_at(hit_at + 2 + k), 2'(s));
    end
    close_run();
  endfunction

  function automatic void report_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, what);
  endfunction

  function automatic void check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endfunction

  always @(posedge clk) begin
    deframe_out_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) apply_packet_size(packet_bytes);
      if (in_valid && !in_stall) deframe_byte(sco_byte, packet_status, packet_end);
      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          report_mismatch($sformatf("result kind %0d with none due", kind));
        end else begin
          want = frames_due.pop_front();
          check_field("kind", kind, want.kind);
          check_field("payload_byte", payload_byte, want.data);
          check_field("frame_seq", frame_seq, want.seq);
          check_field("frames_total", frames_total, want.frames);
          check_field("lost_total", lost_total, want.lost);
          check_field("run_last", run_last, want.last);
        end
      end
    end
  end

  // receiver: random stalls, long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_reqs) begin
      out_stall <= 1'b1;
      hold_left <= HoldCycles;
      hold_taken <= hold_reqs;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 18);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic [7:0] st, input logic last);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sco_byte <= b;
    packet_status <= st;
    packet_end <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_packet(input int len, input logic [7:0] status, input bit from_stream);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (from_stream && tx_bytes.size() != 0) b = tx_bytes.pop_front();
      if (i == len - 1) send_byte(b, status, 1'b1);
      else send_byte(b, 8'($urandom), 1'b0);
    end
  endtask

  task automatic drain_stream();
    while (tx_bytes.size() != 0) send_packet(pkt_size, 8'h00, 1'b1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_packet_size(input logic [5:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    packet_bytes <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    pkt_size = (v == PktShort) ? 24 : 60;
    tx_bytes.delete();
    tx_seq = 0;
  endtask

  // fill below zero means random payload
  function automatic void add_frame(int seq, int fill, bit bad_hdr);
    tx_bytes.push_back(Hdr0);
    tx_bytes.push_back(bad_hdr ? SeqOctet[seq] ^ 8'h01 : SeqOctet[seq]);
    tx_bytes.push_back(Sync);
    repeat (PayloadLen - 1) tx_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    tx_bytes.push_back(8'($urandom));
    tx_seq = (seq + 1) % 4;
  endfunction

  function automatic void add_noise(int n);
    repeat (n) tx_bytes.push_back(8'($urandom));
  endfunction

  task automatic test_clean_frames();
    add_frame(0, 8'h00, 1'b0);
    add_frame(1, 8'hFF, 1'b0);
    add_frame(2, -1, 1'b0);
    drain_stream();
  endtask

  task automatic test_lost_frames();
    add_frame((tx_seq + 2) % 4, -1, 1'b0);
    send_packet(pkt_size, 8'h00, 1'b1);
    add_frame(tx_seq, -1, 1'b0);
    send_packet(pkt_size, 8'hFF, 1'b1);
    add_frame(tx_seq, -1, 1'b0);
    send_packet(pkt_size, 8'h01, 1'b1);
    add_noise(60);
    send_packet(pkt_size, 8'h00, 1'b1);
    add_frame(tx_seq, -1, 1'b1);
    send_packet(pkt_size, 8'h00, 1'b1);
    add_frame((tx_seq + 3) % 4, -1, 1'b0);
    drain_stream();
  endtask

  task automatic test_length_errors();
    send_packet(1, 8'hA5, 1'b0);
    send_packet(70, 8'h00, 1'b0);
    send_packet(pkt_size - 1, 8'h00, 1'b0);
    send_packet(pkt_size + 1, 8'h00, 1'b0);
    add_frame(tx_seq, -1, 1'b0);
    drain_stream();
  endtask

  task automatic test_short_packets();
    write_packet_size(PktShort);
    // not yet aligned: junk is dropped silently, bad lengths still flagged
    send_packet(24, 8'h00, 1'b0);
    send_packet(5, 8'h00, 1'b0);
    repeat (4) add_frame(tx_seq, -1, 1'b0);
    send_packet(24, 8'h00, 1'b1);
    send_packet(24, 8'h80, 1'b1);
    drain_stream();
    add_noise(7);
    repeat (3) add_frame(tx_seq, -1, 1'b0);
    send_packet(24, 8'h00, 1'b1);
    send_packet(24, 8'h00, 1'b1);
    send_packet(24, 8'h40, 1'b1);
    drain_stream();
  endtask

  task automatic test_size_settings();
    logic [5:0] sizes [4];
    sizes = '{6'd0, 6'd63, 6'd25, PktLong};
    foreach (sizes[i]) begin
      write_packet_size(sizes[i]);
      add_frame(0, -1, 1'b0);
      add_frame(1, -1, 1'b0);
      drain_stream();
    end
  endtask

  task automatic test_backpressure();
    hold_reqs++;
    repeat (3) add_frame(tx_seq, -1, 1'b0);
    drain_stream();
    wait_drained();
    add_frame(tx_seq, -1, 1'b0);
    drain_stream();
  endtask

  task automatic test_quiet_stretch();
    quiet = 1'b1;
    repeat (3) add_frame(tx_seq, -1, 1'b0);
    drain_stream();
    quiet = 1'b0;
  endtask

  task automatic test_random_stream(input logic [5:0] v);
    int sent;
    int r;
    int len;
    int seq;
    write_packet_size(v);
    sent = 0;
    while (sent < PhaseBytes) begin
      r = $urandom_range(99);
      if (sent != 0 && r < 6) begin
        len = $urandom_range(1, 70);
        if (len == pkt_size) len++;
        send_packet(len, 8'($urandom), 1'b0);
        sent += len;
      end else begin
        if (sent != 0 && r < 10) add_noise($urandom_range(1, 10));
        else if (sent != 0 && r < 14 && tx_bytes.size() < pkt_size) add_noise(60);
        if (tx_bytes.size() < pkt_size) begin
          seq = ($urandom_range(99) < 85) ? tx_seq : $urandom_range(3);
          add_frame(seq, -1, sent != 0 && $urandom_range(99) < 5);
        end
        if ($urandom_range(99) < 8) send_packet(pkt_size, 8'($urandom_range(1, 255)), 1'b1);
        else send_packet(pkt_size, 8'h00, 1'b1);
        sent += pkt_size;
      end
    end
  endtask

  initial begin
    foreach (store_mem[i]) store_mem[i] = 8'h00;
    apply_packet_size(PktLong);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_clean_frames();
    test_lost_frames();
    test_length_errors();
    test_short_packets();
    test_size_settings();
    test_backpressure();
    test_quiet_stretch();
    test_random_stream(PktShort);
    test_random_stream(PktLong);
    test_random_stream(PktShort);
    test_random_stream(6'($urandom));

    wait_drained();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
